FILE: rtl/core/sdpc_pkg.sv
package sdpc_pkg;

  localparam int unsigned POS_W = 16;
  localparam int unsigned VAL_W = POS_W + 1;

  typedef enum logic [3:0] {
    REQ_STEP_TICK = 4'd0,
    REQ_MS_TICK   = 4'd1,
    REQ_MOVE_ABS  = 4'd2,
    REQ_MOVE_REL  = 4'd3,
    REQ_SET_POS   = 4'd4,
    REQ_STOP      = 4'd5,
    REQ_RELEASE   = 4'd6,
    REQ_EMERGENCY = 4'd7,
    REQ_HOME      = 4'd8
  } req_e;

  typedef enum logic [2:0] {
    MODE_UNKNOWN  = 3'd0,
    MODE_HOMING   = 3'd1,
    MODE_FWD      = 3'd2,
    MODE_REV      = 3'd3,
    MODE_HOLD     = 3'd4,
    MODE_RELEASED = 3'd5,
    MODE_STOPPED  = 3'd6,
    MODE_FAULT    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_HW_FAULT  = 3'd2,
    ST_NOT_VALID = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_HOMING = 2'd1,
    CMD_ABS    = 2'd2,
    CMD_REL    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_SUCCESS     = 3'd0,
    OUT_IN_PROGRESS = 3'd1,
    OUT_HW_ERROR    = 3'd2,
    OUT_EMERGENCY   = 3'd3,
    OUT_STOP        = 3'd4,
    OUT_RELEASE     = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    CFG_FULL_TRAVEL  = 3'd0,
    CFG_HOMING_STEPS = 3'd1,
    CFG_HOLD_MS      = 3'd2,
    CFG_DIAG_MAX_REL = 3'd3,
    CFG_FWD_IS_OPEN  = 3'd4,
    CFG_HOMING_EN    = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] FAULT_EMERG    = 2'b01;
  localparam logic [1:0] FAULT_BOUNDARY = 2'b10;

  localparam int unsigned FLAG_VALID    = 0;
  localparam int unsigned FLAG_MOVING   = 1;
  localparam int unsigned FLAG_FWD      = 2;
  localparam int unsigned FLAG_RELEASED = 3;
  localparam int unsigned FLAG_VALID2   = 4;
  localparam int unsigned FLAG_HOMING   = 5;

  typedef struct packed {
    logic [POS_W-1:0] full_travel;
    logic [POS_W-1:0] homing_steps;
    logic [15:0]      hold_ms;
    logic [POS_W-1:0] diag_max_rel;
    logic             forward_is_open;
    logic             homing_enable;
  } sdpc_cfg_t;

  localparam sdpc_cfg_t CFG_RESET = '{
    full_travel:     16'd1700,
    homing_steps:    16'd1700,
    hold_ms:         16'd500,
    diag_max_rel:    16'd200,
    forward_is_open: 1'b1,
    homing_enable:   1'b1
  };

  typedef struct packed {
    mode_e            mode;
    logic             pos_valid;
    logic [POS_W-1:0] pos_count;
    logic [POS_W-1:0] goal;
    logic [POS_W-1:0] left;
    logic [1:0]       phase;
    logic             coils_on;
    logic             standby;
    logic             dir_fwd;
    logic             released;
    logic             homing;
    logic [15:0]      hold_count;
    cmd_e             cmd;
    outcome_e         outcome;
    logic [1:0]       fault;
  } sdpc_state_t;

  localparam sdpc_state_t STATE_RESET = '{
    mode:       MODE_UNKNOWN,
    pos_valid:  1'b0,
    pos_count:  '0,
    goal:       '0,
    left:       '0,
    phase:      2'd0,
    coils_on:   1'b0,
    standby:    1'b0,
    dir_fwd:    1'b0,
    released:   1'b1,
    homing:     1'b0,
    hold_count: 16'd0,
    cmd:        CMD_NONE,
    outcome:    OUT_SUCCESS,
    fault:      2'b00
  };

  typedef struct packed {
    status_e          status;
    mode_e            mode;
    logic [3:0]       coil_pattern;
    logic             standby_on;
    logic [POS_W-1:0] position_now;
    logic [POS_W-1:0] position_goal;
    logic [POS_W-1:0] steps_left;
    cmd_e             last_cmd;
    outcome_e         last_outcome;
    logic [1:0]       fault_bits;
    logic [5:0]       flag_bits;
  } sdpc_result_t;

  // full-step sequence A+B+, A-B+, A-B-, A+B- as coil bits
  function automatic logic [3:0] coil_pattern_f(input logic [1:0] phase);
    logic [3:0] pat;
    case (phase)
      2'd0:    pat = 4'd5;
      2'd1:    pat = 4'd6;
      2'd2:    pat = 4'd10;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage

FILE: rtl/core/sdpc_if.sv
interface sdpc_in_if;
  logic                                valid;
  logic                                ready;
  logic [3:0]                          req_type;
  logic signed [sdpc_pkg::VAL_W-1:0]   step_value;

  modport source (output valid, req_type, step_value, input ready);
  modport sink   (input valid, req_type, step_value, output ready);
endinterface

interface sdpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [2:0]                  mode;
  logic [3:0]                  coil_pattern;
  logic                        standby_on;
  logic [sdpc_pkg::POS_W-1:0]  position_now;
  logic [sdpc_pkg::POS_W-1:0]  position_goal;
  logic [sdpc_pkg::POS_W-1:0]  steps_left;
  logic [1:0]                  last_cmd;
  logic [2:0]                  last_outcome;
  logic [1:0]                  fault_bits;
  logic [5:0]                  flag_bits;

  modport source (output valid, status, mode, coil_pattern, standby_on, position_now,
                  position_goal, steps_left, last_cmd, last_outcome, fault_bits,
                  flag_bits, input ready);
  modport sink   (input valid, status, mode, coil_pattern, standby_on, position_now,
                  position_goal, steps_left, last_cmd, last_outcome, fault_bits,
                  flag_bits, output ready);
endinterface

interface sdpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sdpc_cfg_regs.sv
module sdpc_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  sdpc_cfg_if.sink             cfg_bus,
  output sdpc_pkg::sdpc_cfg_t  cfg_o
);
  import sdpc_pkg::*;

  sdpc_cfg_t cfg_r, cfg_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg_o         = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_FULL_TRAVEL:  cfg_nxt.full_travel     = cfg_bus.data[POS_W-1:0];
        CFG_HOMING_STEPS: cfg_nxt.homing_steps    = cfg_bus.data[POS_W-1:0];
        CFG_HOLD_MS:      cfg_nxt.hold_ms         = cfg_bus.data;
        CFG_DIAG_MAX_REL: cfg_nxt.diag_max_rel    = cfg_bus.data[POS_W-1:0];
        CFG_FWD_IS_OPEN:  cfg_nxt.forward_is_open = cfg_bus.data[0];
        CFG_HOMING_EN:    cfg_nxt.homing_enable   = cfg_bus.data[0];
        default:          cfg_nxt = cfg_r;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/sdpc_next_state.sv
module sdpc_next_state (
  input  sdpc_pkg::sdpc_state_t                state_i,
  input  sdpc_pkg::sdpc_cfg_t                  cfg_i,
  input  logic [3:0]                           req_i,
  input  logic signed [sdpc_pkg::VAL_W-1:0]    value_i,
  output sdpc_pkg::sdpc_state_t                state_o,
  output sdpc_pkg::sdpc_result_t               result_o
);
  import sdpc_pkg::*;

  function automatic sdpc_state_t coils_off_f(input sdpc_state_t s);
    sdpc_state_t r;
    r          = s;
    r.standby  = 1'b0;
    r.coils_on = 1'b0;
    r.released = 1'b1;
    return r;
  endfunction

  function automatic sdpc_state_t start_f(input sdpc_state_t s, input logic [POS_W-1:0] steps,
                                          input logic fwd);
    sdpc_state_t r;
    r          = s;
    r.left     = steps;
    r.dir_fwd  = fwd;
    r.mode     = fwd ? MODE_FWD : MODE_REV;
    r.outcome  = OUT_IN_PROGRESS;
    r.released = 1'b0;
    r.coils_on = 1'b1;
    r.standby  = 1'b1;
    return r;
  endfunction

  function automatic sdpc_state_t abort_f(input sdpc_state_t s, input logic mov,
                                          input mode_e nm, input outcome_e oc);
    sdpc_state_t r;
    r = s;
    if (mov) begin
      r.left    = '0;
      r.goal    = s.pos_count;
      r.outcome = oc;
    end else if (s.mode != MODE_HOLD) begin
      r.left = '0;
    end
    r        = coils_off_f(r);
    r.homing = 1'b0;
    r.mode   = nm;
    return r;
  endfunction

  sdpc_state_t        s, n;
  status_e            status;
  logic               moving, busy, v_neg, v_zero, v_pos, v_over, at_limit;
  logic [VAL_W-1:0]   v_u, mag;
  logic signed [VAL_W:0] t_rel;
  logic               t_rel_bad;
  logic [15:0]        hold_inc;
  logic [POS_W-1:0]   v_lo;

  always_comb begin
    s        = state_i;
    n        = state_i;
    status   = ST_OK;
    moving   = (s.mode == MODE_HOMING) || (s.mode == MODE_FWD) || (s.mode == MODE_REV);
    busy     = moving || (s.mode == MODE_HOLD);
    v_u      = value_i;
    v_lo     = v_u[POS_W-1:0];
    v_neg    = v_u[VAL_W-1];
    v_zero   = (v_u == '0);
    v_pos    = !v_neg && !v_zero;
    mag      = v_neg ? (~v_u + {{(VAL_W-1){1'b0}}, 1'b1}) : v_u;
    // absolute range check shared by move abs and set pos
    v_over   = v_neg || (v_lo > cfg_i.full_travel);
    t_rel    = $signed({2'b00, s.pos_count}) + $signed({value_i[VAL_W-1], value_i});
    t_rel_bad = t_rel[VAL_W] || (t_rel[VAL_W-1:0] > {1'b0, cfg_i.full_travel});
    at_limit = s.dir_fwd ? (s.pos_count >= cfg_i.full_travel) : (s.pos_count == '0);
    hold_inc = (s.hold_count != 16'hFFFF) ? s.hold_count + 16'd1 : s.hold_count;

    case (req_i)
      REQ_STEP_TICK: begin
        if (moving && (s.left != '0)) begin
          if (s.pos_valid && at_limit) begin
            n           = coils_off_f(s);
            n.mode      = MODE_FAULT;
            n.pos_valid = 1'b0;
            n.left      = '0;
            n.outcome   = OUT_HW_ERROR;
            n.fault     = s.fault | FAULT_BOUNDARY;
            n.homing    = 1'b0;
          end else begin
            n.phase = s.dir_fwd ? s.phase + 2'd1 : s.phase - 2'd1;
            if (s.pos_valid) begin
              n.pos_count = s.dir_fwd ? s.pos_count + 1'b1 : s.pos_count - 1'b1;
            end
            n.left = s.left - 1'b1;
            if (s.left == {{(POS_W-1){1'b0}}, 1'b1}) begin
              if (s.homing) begin
                n.pos_count = '0;
                n.goal      = '0;
                n.pos_valid = 1'b1;
              end
              n.mode       = MODE_HOLD;
              n.outcome    = OUT_SUCCESS;
              n.hold_count = 16'd0;
            end
          end
        end
      end
      REQ_MS_TICK: begin
        if (s.mode == MODE_HOLD) begin
          n.hold_count = hold_inc;
          if (hold_inc >= cfg_i.hold_ms) begin
            n        = coils_off_f(n);
            n.homing = 1'b0;
            n.mode   = MODE_RELEASED;
          end
        end
      end
      REQ_MOVE_ABS, REQ_MOVE_REL, REQ_SET_POS: begin
        if (s.mode == MODE_FAULT) begin
          status = ST_HW_FAULT;
        end else if (busy) begin
          status = ST_BUSY;
        end else if (req_i == REQ_MOVE_ABS) begin
          if (!s.pos_valid) begin
            status = ST_NOT_VALID;
          end else if (v_over) begin
            status = ST_RANGE;
          end else begin
            n.cmd  = CMD_ABS;
            n.goal = v_lo;
            if (v_lo == s.pos_count) begin
              n.left    = '0;
              n.outcome = OUT_SUCCESS;
            end else if (v_lo > s.pos_count) begin
              n = start_f(n, v_lo - s.pos_count, 1'b1);
            end else begin
              n = start_f(n, s.pos_count - v_lo, 1'b0);
            end
          end
        end else if (req_i == REQ_MOVE_REL) begin
          if (s.pos_valid && t_rel_bad) begin
            status = ST_RANGE;
          end else if (!s.pos_valid && (mag > {1'b0, cfg_i.diag_max_rel})) begin
            status = ST_RANGE;
          end else begin
            n.cmd = CMD_REL;
            if (s.pos_valid) begin
              n.goal = t_rel[POS_W-1:0];
            end
            if (v_zero) begin
              n.left    = '0;
              n.outcome = OUT_SUCCESS;
            end else begin
              n = start_f(n, mag[POS_W-1:0], v_pos);
            end
          end
        end else begin
          if (v_over) begin
            status = ST_RANGE;
          end else begin
            n           = coils_off_f(s);
            n.pos_count = v_lo;
            n.goal      = v_lo;
            n.left      = '0;
            n.pos_valid = 1'b1;
            n.mode      = MODE_RELEASED;
          end
        end
      end
      REQ_STOP:    n = abort_f(s, moving, MODE_STOPPED, OUT_STOP);
      REQ_RELEASE: n = abort_f(s, moving, MODE_RELEASED, OUT_RELEASE);
      REQ_EMERGENCY: begin
        n           = coils_off_f(s);
        n.mode      = MODE_FAULT;
        n.pos_valid = 1'b0;
        n.left      = '0;
        n.outcome   = OUT_EMERGENCY;
        n.fault     = s.fault | FAULT_EMERG;
        n.homing    = 1'b0;
      end
      REQ_HOME: begin
        if (s.mode == MODE_FAULT) begin
          status = ST_HW_FAULT;
        end else if (busy) begin
          status = ST_BUSY;
        end else if (!cfg_i.homing_enable) begin
          n.mode = MODE_UNKNOWN;
        end else begin
          n.pos_valid = 1'b0;
          n.pos_count = '0;
          n.goal      = '0;
          n.cmd       = CMD_HOMING;
          n.homing    = 1'b1;
          n           = start_f(n, cfg_i.homing_steps, cfg_i.forward_is_open);
          n.mode      = MODE_HOMING;
        end
      end
      default: n = s;  // undefined request codes leave everything alone
    endcase
  end

  logic n_moving;

  always_comb begin
    n_moving                     = (n.mode == MODE_HOMING) || (n.mode == MODE_FWD) ||
                                   (n.mode == MODE_REV);
    result_o.status              = status;
    result_o.mode                = n.mode;
    result_o.coil_pattern        = n.coils_on ? coil_pattern_f(n.phase) : 4'd0;
    result_o.standby_on          = n.standby;
    result_o.position_now        = n.pos_count;
    result_o.position_goal       = n.goal;
    result_o.steps_left          = n.left;
    result_o.last_cmd            = n.cmd;
    result_o.last_outcome        = n.outcome;
    result_o.fault_bits          = n.fault;
    result_o.flag_bits           = '0;
    result_o.flag_bits[FLAG_VALID]    = n.pos_valid;
    result_o.flag_bits[FLAG_VALID2]   = n.pos_valid;
    result_o.flag_bits[FLAG_MOVING]   = n_moving;
    result_o.flag_bits[FLAG_FWD]      = n_moving && n.dir_fwd;
    result_o.flag_bits[FLAG_RELEASED] = n.released;
    result_o.flag_bits[FLAG_HOMING]   = n.homing;
  end

  assign state_o = n;

endmodule

FILE: rtl/core/stepper_damper_position_controller_core.sv
// Full-step stepper position controller for a damper drive.
//
// Channels:
//   in_bus  - one request per item: req_type (step tick, ms tick, move abs,
//             move rel, set pos, stop, release, emergency, start homing) and a
//             signed step_value (target, delta or new position).
//   out_bus - exactly one snapshot per request: status of the request, mode,
//             coil pattern, standby line, position/goal/steps left, last
//             command and outcome, sticky fault bits and flag bits.
//   cfg_bus - register writes (index 0..5: full travel, homing steps, hold
//             ms, diag max rel, forward-is-open, homing enable). Always ready;
//             write only while no request is in flight. Other indexes drop.
// Timing: a request waits in an input register until the result register is
//   free or draining; then controller state and result register update together.
//   One request per cycle is sustained while out_bus.ready stays high.
// Stalls: the result register holds its snapshot while out_bus.ready is low;
//   the input register keeps accepting until it is full, after which
//   in_bus.ready follows the result register draining.
// Reset (synchronous, rst_n low): position unknown, coils off and released,
//   faults cleared, registers back to their defaults, both channels empty.
module stepper_damper_position_controller_core (
  input logic        clk,
  input logic        rst_n,
  sdpc_in_if.sink    in_bus,
  sdpc_out_if.source out_bus,
  sdpc_cfg_if.sink   cfg_bus
);
  import sdpc_pkg::*;

  sdpc_cfg_t cfg;

  sdpc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_bus(cfg_bus),
    .cfg_o  (cfg)
  );

  // input register stage
  logic                    s1_valid_r;
  logic [3:0]              req_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    s1_adv, in_take;

  // controller state and result register
  sdpc_state_t  state_r, state_nxt;
  sdpc_result_t result_nxt, out_r;
  logic         out_valid_r;

  // the state step fires when the result register is free or being drained
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r   <= in_bus.req_type;
      value_r <= in_bus.step_value;
    end
  end

  sdpc_next_state u_next_state (
    .state_i (state_r),
    .cfg_i   (cfg),
    .req_i   (req_r),
    .value_i (value_r),
    .state_o (state_nxt),
    .result_o(result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.status        = out_r.status;
  assign out_bus.mode          = out_r.mode;
  assign out_bus.coil_pattern  = out_r.coil_pattern;
  assign out_bus.standby_on    = out_r.standby_on;
  assign out_bus.position_now  = out_r.position_now;
  assign out_bus.position_goal = out_r.position_goal;
  assign out_bus.steps_left    = out_r.steps_left;
  assign out_bus.last_cmd      = out_r.last_cmd;
  assign out_bus.last_outcome  = out_r.last_outcome;
  assign out_bus.fault_bits    = out_r.fault_bits;
  assign out_bus.flag_bits     = out_r.flag_bits;

  // coils, standby and released always move together
  a_coil_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.standby == state_r.coils_on) && (state_r.released == !state_r.coils_on))
    else $error("coil, standby and released state disagree");

  // any motion mode has the driver energized
  a_moving_energized: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r.mode == MODE_HOMING) || (state_r.mode == MODE_FWD) ||
     (state_r.mode == MODE_REV)) |-> state_r.coils_on)
    else $error("motion mode with coils off");

  // homing flag only survives through the homing run and its hold
  a_homing_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.homing |-> ((state_r.mode == MODE_HOMING) || (state_r.mode == MODE_HOLD)))
    else $error("homing flag set outside homing or hold");

  // fault mode always comes with a recorded fault and an invalid position
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_FAULT) |-> (!state_r.pos_valid && (state_r.fault != 2'b00)))
    else $error("fault mode without fault record");

  // every state step produces a snapshot in the next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("state step without a result");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sdpc_pkg::*;

  // quiet cycles (no request, snapshot or register write) before we give up
  localparam int unsigned STALL_LIMIT = 2000;
  // top code of the 4-bit request field; has no meaning in the block
  localparam logic [3:0] REQ_UNDEFINED_TOP = 4'd15;
  // coil drive per phase index: A+B+, A-B+, A-B-, A+B-
  localparam logic [3:0] COIL_SEQ [4] = '{4'd5, 4'd6, 4'd10, 4'd9};

  typedef struct {
    logic [3:0] req;
    int         val;
    bit         typed;  // status/mode below are hand-written expectations
    status_e    st;
    mode_e      md;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sdpc_in_if  in_if ();
  sdpc_out_if out_if ();
  sdpc_cfg_if cfg_if ();

  stepper_damper_position_controller_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if),
    .cfg_bus(cfg_if)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Controller shadow: state and registers as the block should hold them.
  // ---------------------------------------------------------------------------
  mode_e       m_mode;
  bit          m_valid, m_coils, m_stby, m_dir, m_rel, m_homing;
  logic [15:0] m_pos, m_goal, m_left, m_hold;
  logic [1:0]  m_phase;
  cmd_e        m_cmd;
  outcome_e    m_out;
  logic [1:0]  m_fault;
  sdpc_cfg_t   cfg_shadow;

  sdpc_result_t snapshots_due[$];  // one expected snapshot per accepted request

  bit          calm = 1'b0;        // no idling on either side while set
  int unsigned items_sent = 0;
  int unsigned snapshots_seen = 0;
  int unsigned settings_loaded = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  modes_seen = '0;

  // Directed opening, reset register values (travel 1700, diag limit 200).
  plan_row_t opening_plan [25] = '{
    '{REQ_MS_TICK,       0,      1, ST_OK,        MODE_UNKNOWN},   // tick outside hold
    '{REQ_STEP_TICK,     0,      1, ST_OK,        MODE_UNKNOWN},   // tick while idle
    '{REQ_MOVE_ABS,      100,    1, ST_NOT_VALID, MODE_UNKNOWN},
    '{REQ_MOVE_REL,      201,    1, ST_RANGE,     MODE_UNKNOWN},   // just past diag limit
    '{REQ_MOVE_REL,      -200,   1, ST_OK,        MODE_REV},       // at diag limit
    '{REQ_STEP_TICK,     0,      0, ST_OK,        MODE_UNKNOWN},   // uncounted step
    '{REQ_MOVE_ABS,      5,      1, ST_BUSY,      MODE_REV},
    '{REQ_STOP,          0,      1, ST_OK,        MODE_STOPPED},
    '{REQ_SET_POS,       1701,   1, ST_RANGE,     MODE_STOPPED},
    '{REQ_SET_POS,       -65535, 1, ST_RANGE,     MODE_STOPPED},
    '{REQ_SET_POS,       1700,   1, ST_OK,        MODE_RELEASED},  // top of travel
    '{REQ_MOVE_REL,      1,      1, ST_RANGE,     MODE_RELEASED},
    '{REQ_MOVE_ABS,      1700,   1, ST_OK,        MODE_RELEASED},  // zero-length move
    '{REQ_MOVE_ABS,      1698,   0, ST_OK,        MODE_UNKNOWN},
    '{REQ_STEP_TICK,     0,      0, ST_OK,        MODE_UNKNOWN},
    '{REQ_STEP_TICK,     0,      0, ST_OK,        MODE_UNKNOWN},   // lands, enters hold
    '{REQ_MOVE_REL,      -1,     1, ST_BUSY,      MODE_HOLD},
    '{REQ_HOME,          0,      1, ST_BUSY,      MODE_HOLD},
    '{REQ_RELEASE,       0,      1, ST_OK,        MODE_RELEASED},
    '{REQ_UNDEFINED_TOP, 65535,  1, ST_OK,        MODE_RELEASED},
    '{REQ_EMERGENCY,     0,      1, ST_OK,        MODE_FAULT},
    '{REQ_MOVE_ABS,      0,      1, ST_HW_FAULT,  MODE_FAULT},
    '{REQ_HOME,          0,      1, ST_HW_FAULT,  MODE_FAULT},
    '{REQ_STOP,          0,      1, ST_OK,        MODE_STOPPED},   // stop clears fault mode
    '{REQ_HOME,          0,      1, ST_OK,        MODE_HOMING}
  };

  function automatic void shadow_reset();
    m_mode = MODE_UNKNOWN; m_valid = 1'b0; m_pos = '0; m_goal = '0; m_left = '0;
    m_phase = '0; m_coils = 1'b0; m_stby = 1'b0; m_dir = 1'b0; m_rel = 1'b1;
    m_homing = 1'b0; m_hold = '0; m_cmd = CMD_NONE; m_out = OUT_SUCCESS; m_fault = '0;
    cfg_shadow = CFG_RESET;
  endfunction

  function automatic bit in_motion();
    return m_mode inside {MODE_HOMING, MODE_FWD, MODE_REV};
  endfunction

  function automatic void drop_drive();
    m_stby = 1'b0;
    m_coils = 1'b0;
    m_rel = 1'b1;
  endfunction

  function automatic void begin_motion(input logic [15:0] steps, input bit fwd);
    m_left = steps;
    m_dir = fwd;
    m_mode = fwd ? MODE_FWD : MODE_REV;
    m_out = OUT_IN_PROGRESS;
    m_rel = 1'b0;
    m_coils = 1'b1;
    m_stby = 1'b1;
  endfunction

  function automatic void step_once();
    if (!in_motion() || m_left == 16'd0) return;
    // counted position about to leave the travel window
    if (m_valid && (m_dir ? (m_pos >= cfg_shadow.full_travel) : (m_pos == 16'd0))) begin
      drop_drive();
      m_mode = MODE_FAULT;
      m_valid = 1'b0;
      m_left = '0;
      m_out = OUT_HW_ERROR;
      m_fault = m_fault | FAULT_BOUNDARY;
      m_homing = 1'b0;
      return;
    end
    m_phase = m_dir ? m_phase + 2'd1 : m_phase + 2'd3;
    if (m_valid) m_pos = m_dir ? m_pos + 16'd1 : m_pos - 16'd1;
    m_left = m_left - 16'd1;
    if (m_left == 16'd0) begin
      if (m_homing) begin
        m_pos = '0;
        m_goal = '0;
        m_valid = 1'b1;
      end
      m_mode = MODE_HOLD;
      m_out = OUT_SUCCESS;
      m_hold = '0;
    end
  endfunction

  function automatic void abort_motion(input mode_e nm, input outcome_e oc);
    if (in_motion()) begin
      m_left = '0;
      m_goal = m_pos;
      m_out = oc;
    end else if (m_mode != MODE_HOLD) begin
      m_left = '0;
    end
    drop_drive();
    m_homing = 1'b0;
    m_mode = nm;
  endfunction

  // Applies one request to the shadow and returns the snapshot it must produce.
  function automatic sdpc_result_t damper_next(input logic [3:0] req,
                                               input logic signed [16:0] val);
    sdpc_result_t r;
    status_e      st;
    int           v, mag, t, pos, ft;
    st = ST_OK;
    v = val;
    mag = (v < 0) ? -v : v;
    pos = m_pos;
    ft = cfg_shadow.full_travel;
    case (req)
      REQ_STEP_TICK: step_once();
      REQ_MS_TICK: begin
        if (m_mode == MODE_HOLD) begin
          if (m_hold != 16'hFFFF) m_hold = m_hold + 16'd1;
          if (m_hold >= cfg_shadow.hold_ms) begin
            drop_drive();
            m_homing = 1'b0;
            m_mode = MODE_RELEASED;
          end
        end
      end
      REQ_MOVE_ABS, REQ_MOVE_REL, REQ_SET_POS: begin
        if (m_mode == MODE_FAULT) st = ST_HW_FAULT;
        else if (in_motion() || m_mode == MODE_HOLD) st = ST_BUSY;
        else if (req == REQ_MOVE_ABS) begin
          if (!m_valid) st = ST_NOT_VALID;
          else if (v < 0 || v > ft) st = ST_RANGE;
          else begin
            m_cmd = CMD_ABS;
            m_goal = 16'(v);
            if (v == pos) begin
              m_left = '0;
              m_out = OUT_SUCCESS;
            end else if (v > pos) begin_motion(16'(v - pos), 1'b1);
            else begin_motion(16'(pos - v), 1'b0);
          end
        end else if (req == REQ_MOVE_REL) begin
          if (m_valid) begin
            t = pos + v;
            if (t < 0 || t > ft) st = ST_RANGE;
            else begin
              m_cmd = CMD_REL;
              m_goal = 16'(t);
              if (v == 0) begin
                m_left = '0;
                m_out = OUT_SUCCESS;
              end else begin_motion(16'(mag), v > 0);
            end
          end else if (mag > int'(cfg_shadow.diag_max_rel)) st = ST_RANGE;
          else begin
            // uncounted diagnostic move
            m_cmd = CMD_REL;
            if (v == 0) begin
              m_left = '0;
              m_out = OUT_SUCCESS;
            end else begin_motion(16'(mag), v > 0);
          end
        end else begin
          if (v < 0 || v > ft) st = ST_RANGE;
          else begin
            drop_drive();
            m_pos = 16'(v);
            m_goal = m_pos;
            m_left = '0;
            m_valid = 1'b1;
            m_mode = MODE_RELEASED;
          end
        end
      end
      REQ_STOP:    abort_motion(MODE_STOPPED, OUT_STOP);
      REQ_RELEASE: abort_motion(MODE_RELEASED, OUT_RELEASE);
      REQ_EMERGENCY: begin
        drop_drive();
        m_mode = MODE_FAULT;
        m_valid = 1'b0;
        m_left = '0;
        m_out = OUT_EMERGENCY;
        m_fault = m_fault | FAULT_EMERG;
        m_homing = 1'b0;
      end
      REQ_HOME: begin
        if (m_mode == MODE_FAULT) st = ST_HW_FAULT;
        else if (in_motion() || m_mode == MODE_HOLD) st = ST_BUSY;
        else if (!cfg_shadow.homing_enable) m_mode = MODE_UNKNOWN;
        else begin
          m_valid = 1'b0;
          m_pos = '0;
          m_goal = '0;
          m_cmd = CMD_HOMING;
          m_homing = 1'b1;
          begin_motion(cfg_shadow.homing_steps, cfg_shadow.forward_is_open);
          m_mode = MODE_HOMING;
        end
      end
      default: ;  // undefined codes change nothing
    endcase

    r.status        = st;
    r.mode          = m_mode;
    r.coil_pattern  = m_coils ? COIL_SEQ[m_phase] : 4'd0;
    r.standby_on    = m_stby;
    r.position_now  = m_pos;
    r.position_goal = m_goal;
    r.steps_left    = m_left;
    r.last_cmd      = m_cmd;
    r.last_outcome  = m_out;
    r.fault_bits    = m_fault;
    r.flag_bits     = '0;
    r.flag_bits[FLAG_VALID]    = m_valid;
    r.flag_bits[FLAG_VALID2]   = m_valid;
    r.flag_bits[FLAG_MOVING]   = in_motion();
    r.flag_bits[FLAG_FWD]      = in_motion() && m_dir;
    r.flag_bits[FLAG_RELEASED] = m_rel;
    r.flag_bits[FLAG_HOMING]   = m_homing;
    modes_seen[m_mode] = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [3:0] req, input int val, input bit typed,
                          input status_e st, input mode_e md);
    sdpc_result_t snap;
    // random gaps; valid only drops here, so it never toggles twice in a step
    while (!calm && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.req_type   <= req;
    in_if.step_value <= 17'(val);
    do @(posedge clk); while (in_if.ready !== 1'b1);
    snap = damper_next(req, 17'(val));
    if (typed) begin
      snap.status = st;
      snap.mode = md;
    end
    snapshots_due.push_back(snap);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic issue(input logic [3:0] req, input int val);
    send_req(req, val, 1'b0, ST_OK, MODE_UNKNOWN);
  endtask

  function automatic int any_value();
    return int'(17'($urandom));
  endfunction

  task automatic tick_run(input logic [3:0] kind, input int unsigned n);
    repeat (n) issue(kind, any_value());
  endtask

  // enough step ticks to finish a short motion, at times one more; a long motion gets at most 21
  function automatic int unsigned motion_ticks();
    return (m_left > 16'd20 ? $urandom_range(20) : int'(m_left)) + $urandom_range(1);
  endfunction

  function automatic int unsigned hold_ticks();
    return (cfg_shadow.hold_ms > 16'd20 ? $urandom_range(20) : int'(cfg_shadow.hold_ms))
           + $urandom_range(2);
  endfunction

  // Stop offering requests, let every snapshot come back, then a few spare cycles.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (snapshots_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(input sdpc_cfg_t s);
    cfg_idx_e idx;
    idx = CFG_FULL_TRAVEL;
    repeat (idx.num()) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      case (idx)
        CFG_FULL_TRAVEL:  cfg_if.data <= s.full_travel;
        CFG_HOMING_STEPS: cfg_if.data <= s.homing_steps;
        CFG_HOLD_MS:      cfg_if.data <= s.hold_ms;
        CFG_DIAG_MAX_REL: cfg_if.data <= s.diag_max_rel;
        // junk in the upper bits of the one-bit registers must be dropped
        CFG_FWD_IS_OPEN:  cfg_if.data <= {15'($urandom), s.forward_is_open};
        default:          cfg_if.data <= {15'($urandom), s.homing_enable};
      endcase
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
      @(negedge clk);
      idx = idx.next();
    end
    cfg_if.valid <= 1'b0;
    cfg_shadow = s;
    settings_loaded++;
  endtask

  // Mostly complete sequences (home, move then tick it out, hold then release)
  // with random content; the rest aborts and raw noise.
  task automatic random_burst(input int unsigned quota);
    int unsigned start;
    int          ft, lo, hi, lim, val;
    start = items_sent;
    while (items_sent - start < quota) begin
      ft = cfg_shadow.full_travel;
      case ($urandom_range(9))
        0, 1: begin
          issue(REQ_HOME, any_value());
          tick_run(REQ_STEP_TICK, motion_ticks());
          tick_run(REQ_MS_TICK, hold_ticks());
        end
        2, 3: begin
          if (!m_valid || $urandom_range(3) == 0) begin
            case ($urandom_range(7))
              0:       val = ft + 1;
              1:       val = -1 - int'($urandom_range(5));
              default: val = $urandom_range(ft);
            endcase
            issue(REQ_SET_POS, val);
          end
          lo = (int'(m_pos) > 10) ? int'(m_pos) - 10 : 0;
          hi = (int'(m_pos) + 10 < ft) ? int'(m_pos) + 10 : ft;
          val = ($urandom_range(9) == 0) ? ft + 1 : int'($urandom_range(hi, lo));
          issue(REQ_MOVE_ABS, val);
          tick_run(REQ_STEP_TICK, motion_ticks());
          tick_run(REQ_MS_TICK, hold_ticks());
        end
        4, 5: begin
          lim = (!m_valid && cfg_shadow.diag_max_rel < 16'd12) ?
                int'(cfg_shadow.diag_max_rel) + 1 : 12;
          issue(REQ_MOVE_REL, int'($urandom_range(2 * lim)) - lim);
          tick_run(REQ_STEP_TICK, motion_ticks());
          if ($urandom_range(1) == 0) tick_run(REQ_MS_TICK, hold_ticks());
        end
        6: begin
          case ($urandom_range(4))
            0:       issue(REQ_EMERGENCY, any_value());
            1, 2:    issue(REQ_STOP, any_value());
            default: issue(REQ_RELEASE, any_value());
          endcase
        end
        7: tick_run(REQ_MS_TICK, hold_ticks());
        default: begin
          repeat ($urandom_range(3, 1)) issue(4'($urandom), any_value());
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Snapshot side: random back-pressure, plus one long hold-off so the block
  // fills and stalls its request channel.
  // ---------------------------------------------------------------------------
  initial begin : snapshot_sink
    int unsigned held;
    bit          pressure_done;
    held = 0;
    pressure_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && snapshots_seen >= 60) begin
        pressure_done = 1'b1;
        held = 48;
      end
      if (held != 0) begin
        held--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : snapshot_check
    sdpc_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      snapshots_seen++;
      if (snapshots_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: snapshot with no request pending, expected none got mode %0h",
                 $time, out_if.mode);
      end else begin
        want = snapshots_due.pop_front();
        compare_field("status",        want.status,        out_if.status);
        compare_field("mode",          want.mode,          out_if.mode);
        compare_field("coil_pattern",  want.coil_pattern,  out_if.coil_pattern);
        compare_field("standby_on",    want.standby_on,    out_if.standby_on);
        compare_field("position_now",  want.position_now,  out_if.position_now);
        compare_field("position_goal", want.position_goal, out_if.position_goal);
        compare_field("steps_left",    want.steps_left,    out_if.steps_left);
        compare_field("last_cmd",      want.last_cmd,      out_if.last_cmd);
        compare_field("last_outcome",  want.last_outcome,  out_if.last_outcome);
        compare_field("fault_bits",    want.fault_bits,    out_if.fault_bits);
        compare_field("flag_bits",     want.flag_bits,     out_if.flag_bits);
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles, %0d snapshots outstanding",
                 $time, quiet_cycles, snapshots_due.size());
        $display("stepper_damper_position_controller_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sdpc_cfg_t s;
    in_if.valid      = 1'b0;
    in_if.req_type   = REQ_STEP_TICK;
    in_if.step_value = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_FULL_TRAVEL;
    cfg_if.data      = '0;
    rst_n            = 1'b0;
    shadow_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening on reset registers; ends with a long homing in flight
    foreach (opening_plan[i])
      send_req(opening_plan[i].req, opening_plan[i].val, opening_plan[i].typed,
               opening_plan[i].st, opening_plan[i].md);
    settle();

    // short travel, few homing steps, short hold
    s = '{full_travel: 16'd12, homing_steps: 16'd4, hold_ms: 16'd2,
          diag_max_rel: 16'd3, forward_is_open: 1'b1, homing_enable: 1'b1};
    load_settings(s);
    random_burst(110);
    // leave a counted forward move running across the next register change
    issue(REQ_STOP, 0);
    issue(REQ_SET_POS, 0);
    issue(REQ_MOVE_ABS, cfg_shadow.full_travel);
    tick_run(REQ_STEP_TICK, 2);
    settle();

    // lower extremes: travel shrinks under the running move -> boundary fault,
    // zero homing steps, zero hold, zero diag limit, reverse opens
    s = '{full_travel: 16'd1, homing_steps: 16'd0, hold_ms: 16'd0,
          diag_max_rel: 16'd0, forward_is_open: 1'b0, homing_enable: 1'b1};
    load_settings(s);
    issue(REQ_STEP_TICK, 0);
    random_burst(90);
    settle();

    // upper extremes, homing disabled; no idling on either side here
    calm = 1'b1;
    s = '{full_travel: 16'hFFFF, homing_steps: 16'hFFFF, hold_ms: 16'hFFFF,
          diag_max_rel: 16'hFFFF, forward_is_open: 1'b1, homing_enable: 1'b0};
    load_settings(s);
    random_burst(90);
    settle();
    calm = 1'b0;

    // random small setting, homing toward the reverse direction
    s.full_travel     = 16'($urandom_range(40, 1));
    s.homing_steps    = 16'($urandom_range(6));
    s.hold_ms         = 16'($urandom_range(5));
    s.diag_max_rel    = 16'($urandom_range(20));
    s.forward_is_open = 1'b0;
    s.homing_enable   = 1'b1;
    load_settings(s);
    random_burst(100);
    settle();
    repeat (8) @(posedge clk);  // catch any stray snapshot

    $display("Covered %0d requests over %0d register settings, %0d snapshots checked.",
             items_sent, settings_loaded, snapshots_seen);
    $display("Modes entered (bit per mode): %b, sticky faults at end: %b",
             modes_seen, m_fault);
    if (mismatches == 0 && snapshots_due.size() == 0)
      $display("stepper_damper_position_controller_core verification clean");
    else
      $display("stepper_damper_position_controller_core verification failed");
    $finish;
  end

endmodule
